/* rtl/core/vgbs_pkg.sv */
package vgbs_pkg;

    localparam int MAX_NODES_PER_SIDE = 64;
    localparam int FRAC_BITS          = 16;

    localparam int DATA_W     = 32;
    localparam int IDX_W      = 6;
    localparam int MEM_W      = 2 * DATA_W;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CELL_W     = PROD_W - 2 * FRAC_BITS;
    localparam int SUM_W      = DATA_W + FRAC_BITS + 2;
    localparam int NODE_BITS  = $clog2(MAX_NODES_PER_SIDE);
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int NODE_COUNT = MAX_NODES_PER_SIDE * MAX_NODES_PER_SIDE;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] REQ_SET     = 3'd0;
    localparam logic [2:0] REQ_ADD     = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_SAMPLE  = 3'd3;
    localparam logic [2:0] REQ_NEAREST = 3'd4;

    localparam logic [2:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] CFG_CELLS_UNIT_X = 3'd2;
    localparam logic [2:0] CFG_CELLS_UNIT_Y = 3'd3;
    localparam logic [2:0] CFG_CELLS_ACROSS = 3'd4;
    localparam logic [2:0] CFG_CELLS_DOWN   = 3'd5;

    typedef logic [ADDR_BITS-1:0] node_addr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_READ,
        ST_READ_OUT,
        ST_NORM,
        ST_EVAL,
        ST_CORNER,
        ST_LERP
    } state_t;

    typedef struct packed {
        logic              we;
        node_addr_t        addr;
        logic [MEM_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic                     en;
        logic signed [DATA_W:0]   op_a;
        logic signed [DATA_W:0]   op_b;
        logic signed [DATA_W-1:0] base;
    } mac_req_t;

    function automatic node_addr_t node_addr(input logic [IDX_W:0] col,
                                             input logic [IDX_W:0] row);
        int unsigned lin;
        lin = int'(row) * MAX_NODES_PER_SIDE + int'(col);
        return node_addr_t'(lin);
    endfunction

    function automatic logic in_memory(input logic [IDX_W:0] col,
                                       input logic [IDX_W:0] row);
        return (int'(col) < MAX_NODES_PER_SIDE) && (int'(row) < MAX_NODES_PER_SIDE);
    endfunction

endpackage

/* rtl/core/vgbs_mem.sv */
module vgbs_mem
    import vgbs_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [MEM_W-1:0] rdata
);

    logic [MEM_W-1:0] mem [NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule

/* rtl/core/vgbs_mac.sv */
module vgbs_mac
    import vgbs_pkg::*;
(
    input  logic                     clk,
    input  mac_req_t                 req,
    output logic [PROD_W-1:0]        prod,
    output logic signed [DATA_W-1:0] lerp
);

    logic signed [2*DATA_W+1:0] prod_reg;
    logic signed [DATA_W-1:0]   base_reg;
    logic [SUM_W-1:0]           sum;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= $signed(req.op_a) * $signed(req.op_b);
            base_reg <= req.base;
        end
    end

    // base * one + (b - a) * w, rounded half up, floored shift
    assign sum  = (SUM_W'(base_reg) << FRAC_BITS) + prod_reg[SUM_W-1:0] + ROUND_HALF;
    assign prod = prod_reg[PROD_W-1:0];
    assign lerp = sum[FRAC_BITS+DATA_W-1:FRAC_BITS];

endmodule

/* rtl/core/vector_grid_bilinear_sampler.sv */
// Channel   Dir  Ports                                              Transfer
// request   in   start, req_type, node_col, node_row, value_x,     start && !busy
//                value_y, pos_x, pos_y
// result    out  done, vec_x, vec_y, nearest_col, nearest_row,     done, one cycle
//                outside
// config    in   cfg_we, cfg_index, cfg_data                       cfg_we, no wait
//
// Set and add raise no done. Read, nearest and sample raise done in the same cycle busy
// drops; an off-grid read raises done without going busy, and an outside sample ends
// before the corner reads. Samples share one multiplier (two scalings, six interpolation
// products) and the single grid memory port (four corner reads).
// rst_n clears the sequencer and loads the register defaults; grid contents stay
// undefined until written. The receiver cannot stall: done lasts one cycle.
module vector_grid_bilinear_sampler
    import vgbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               req_type,
    input  logic [IDX_W-1:0]         node_col,
    input  logic [IDX_W-1:0]         node_row,
    input  logic signed [DATA_W-1:0] value_x,
    input  logic signed [DATA_W-1:0] value_y,
    input  logic signed [DATA_W-1:0] pos_x,
    input  logic signed [DATA_W-1:0] pos_y,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    output logic                     done,
    output logic signed [DATA_W-1:0] vec_x,
    output logic signed [DATA_W-1:0] vec_y,
    output logic [IDX_W-1:0]         nearest_col,
    output logic [IDX_W-1:0]         nearest_row,
    output logic                     outside
);

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       done_reg, done_next;

    logic signed [DATA_W-1:0] origin_x_reg, origin_y_reg;
    logic [DATA_W-1:0]        cpu_x_reg, cpu_y_reg;
    logic [IDX_W-1:0]         cells_across_reg, cells_down_reg;

    logic [2:0]               req_reg;
    logic [IDX_W-1:0]         col_reg, row_reg;
    logic [DATA_W-1:0]        val_x_reg, val_y_reg;
    logic [DATA_W-1:0]        pos_x_reg, pos_y_reg;
    logic [PROD_W-1:0]        prod_x_reg, prod_y_reg;
    logic                     negx_reg, negy_reg;
    logic [IDX_W-1:0]         cx_reg, cy_reg;
    logic [FRAC_BITS-1:0]     wx_reg, wy_reg;
    logic [DATA_W-1:0]        cor_x_reg [4];
    logic [DATA_W-1:0]        cor_y_reg [4];
    logic [DATA_W-1:0]        t_reg [4];
    logic [DATA_W-1:0]        vec_x_reg, vec_y_reg;
    logic [IDX_W-1:0]         ncol_reg, nrow_reg;
    logic                     outside_reg;

    mem_req_t                 mem_req;
    logic [MEM_W-1:0]         mem_rdata;
    mac_req_t                 mac_req;
    logic [PROD_W-1:0]        mac_prod;
    logic signed [DATA_W-1:0] mac_lerp;

    logic                     accept;
    logic                     in_grid_in;
    logic [DATA_W+1:0]        diff_x, diff_y, abs_x, abs_y;
    logic [CELL_W-1:0]        hi_x, hi_y;
    logic                     neg_x, neg_y, out_x, out_y, sample_out;
    logic [IDX_W-1:0]         near_col, near_row;
    logic [1:0]               rd_k, cap_k;
    logic [IDX_W:0]           rd_col, rd_row, cap_col, cap_row;
    logic [IDX_W:0]           col_ext, row_ext;
    logic [DATA_W-1:0]        lo_v, hi_v;
    logic [FRAC_BITS-1:0]     w_v;

    vgbs_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    vgbs_mac u_mac
    (
        .clk  (clk),
        .req  (mac_req),
        .prod (mac_prod),
        .lerp (mac_lerp)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign in_grid_in = (node_col <= cells_across_reg) && (node_row <= cells_down_reg) &&
                        in_memory({1'b0, node_col}, {1'b0, node_row});

    assign col_ext = {1'b0, col_reg};
    assign row_ext = {1'b0, row_reg};

    assign diff_x = {{2{pos_x_reg[DATA_W-1]}}, pos_x_reg} -
                    {{2{origin_x_reg[DATA_W-1]}}, origin_x_reg};
    assign diff_y = {{2{pos_y_reg[DATA_W-1]}}, pos_y_reg} -
                    {{2{origin_y_reg[DATA_W-1]}}, origin_y_reg};
    assign abs_x  = diff_x[DATA_W+1] ? -diff_x : diff_x;
    assign abs_y  = diff_y[DATA_W+1] ? -diff_y : diff_y;

    assign hi_x  = prod_x_reg[PROD_W-1:2*FRAC_BITS];
    assign hi_y  = prod_y_reg[PROD_W-1:2*FRAC_BITS];
    assign neg_x = negx_reg && (prod_x_reg != '0);
    assign neg_y = negy_reg && (prod_y_reg != '0);
    assign out_x = neg_x || (hi_x >= CELL_W'(cells_across_reg));
    assign out_y = neg_y || (hi_y >= CELL_W'(cells_down_reg));
    assign sample_out = out_x || out_y;

    always_comb
    begin
        if (neg_x)
        begin
            near_col = '0;
        end
        else if (hi_x >= CELL_W'(cells_across_reg))
        begin
            near_col = cells_across_reg;
        end
        else
        begin
            near_col = hi_x[IDX_W-1:0] + IDX_W'(prod_x_reg[2*FRAC_BITS-1]);
        end
        if (neg_y)
        begin
            near_row = '0;
        end
        else if (hi_y >= CELL_W'(cells_down_reg))
        begin
            near_row = cells_down_reg;
        end
        else
        begin
            near_row = hi_y[IDX_W-1:0] + IDX_W'(prod_y_reg[2*FRAC_BITS-1]);
        end
    end

    // corner order: (cx,cy) (cx,cy+1) (cx+1,cy) (cx+1,cy+1)
    assign rd_k    = step_reg[1:0];
    assign cap_k   = step_reg[1:0] - 2'd1;
    assign rd_col  = {1'b0, cx_reg} + (IDX_W+1)'(rd_k[1]);
    assign rd_row  = {1'b0, cy_reg} + (IDX_W+1)'(rd_k[0]);
    assign cap_col = {1'b0, cx_reg} + (IDX_W+1)'(cap_k[1]);
    assign cap_row = {1'b0, cy_reg} + (IDX_W+1)'(cap_k[0]);

    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin lo_v = cor_x_reg[0]; hi_v = cor_x_reg[1]; w_v = wy_reg; end
            3'd1:    begin lo_v = cor_y_reg[0]; hi_v = cor_y_reg[1]; w_v = wy_reg; end
            3'd2:    begin lo_v = cor_x_reg[2]; hi_v = cor_x_reg[3]; w_v = wy_reg; end
            3'd3:    begin lo_v = cor_y_reg[2]; hi_v = cor_y_reg[3]; w_v = wy_reg; end
            3'd4:    begin lo_v = t_reg[0];     hi_v = t_reg[2];     w_v = wx_reg; end
            default: begin lo_v = t_reg[1];     hi_v = t_reg[3];     w_v = wx_reg; end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        done_next     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = node_addr(col_ext, row_ext);
        mem_req.wdata = {val_y_reg, val_x_reg};
        mac_req.en    = 1'b0;
        mac_req.op_a  = {1'b0, abs_x[DATA_W-1:0]};
        mac_req.op_b  = {1'b0, cpu_x_reg};
        mac_req.base  = lo_v;

        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    priority if (req_type == REQ_SET)
                    begin
                        state_next = in_grid_in ? ST_WRITE : ST_IDLE;
                    end
                    else if (req_type == REQ_ADD)
                    begin
                        state_next = in_grid_in ? ST_ADD_RD : ST_IDLE;
                    end
                    else if (req_type == REQ_READ)
                    begin
                        state_next = in_grid_in ? ST_READ : ST_IDLE;
                        done_next  = !in_grid_in;
                    end
                    else if (req_type == REQ_SAMPLE || req_type == REQ_NEAREST)
                    begin
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_WRITE:
            begin
                mem_req.we = 1'b1;
                state_next = ST_IDLE;
            end

            ST_ADD_RD:
            begin
                state_next = ST_ADD_WR;
            end

            ST_ADD_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = {mem_rdata[MEM_W-1:DATA_W] + val_y_reg,
                                 mem_rdata[DATA_W-1:0] + val_x_reg};
                state_next    = ST_IDLE;
            end

            ST_READ:
            begin
                state_next = ST_READ_OUT;
            end

            ST_READ_OUT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_NORM:
            begin
                mac_req.en = (step_reg != 3'd2);
                if (step_reg != 3'd0)
                begin
                    mac_req.op_a = {1'b0, abs_y[DATA_W-1:0]};
                    mac_req.op_b = {1'b0, cpu_y_reg};
                end
                if (step_reg == 3'd2)
                begin
                    step_next  = '0;
                    state_next = ST_EVAL;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            ST_EVAL:
            begin
                if (req_reg == REQ_NEAREST || sample_out)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CORNER;
                end
            end

            ST_CORNER:
            begin
                mem_req.addr = node_addr(rd_col, rd_row);
                if (step_reg == 3'd4)
                begin
                    step_next  = '0;
                    state_next = ST_LERP;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            ST_LERP:
            begin
                mac_req.en   = (step_reg <= 3'd5);
                mac_req.op_a = {hi_v[DATA_W-1], hi_v} - {lo_v[DATA_W-1], lo_v};
                mac_req.op_b = (DATA_W+1)'(w_v);
                if (step_reg == 3'd6)
                begin
                    done_next  = 1'b1;
                    step_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            done_reg         <= 1'b0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            cpu_x_reg        <= DATA_W'(65536);
            cpu_y_reg        <= DATA_W'(65536);
            cells_across_reg <= IDX_W'(63);
            cells_down_reg   <= IDX_W'(63);
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                    CFG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                    CFG_CELLS_UNIT_X: cpu_x_reg        <= cfg_data;
                    CFG_CELLS_UNIT_Y: cpu_y_reg        <= cfg_data;
                    CFG_CELLS_ACROSS: cells_across_reg <= cfg_data[IDX_W-1:0];
                    CFG_CELLS_DOWN:   cells_down_reg   <= cfg_data[IDX_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_reg   <= req_type;
                    col_reg   <= node_col;
                    row_reg   <= node_row;
                    val_x_reg <= value_x;
                    val_y_reg <= value_y;
                    pos_x_reg <= pos_x;
                    pos_y_reg <= pos_y;
                    if (req_type == REQ_READ && !in_grid_in)
                    begin
                        vec_x_reg   <= '0;
                        vec_y_reg   <= '0;
                        ncol_reg    <= '0;
                        nrow_reg    <= '0;
                        outside_reg <= 1'b1;
                    end
                end
            end

            ST_READ_OUT:
            begin
                vec_x_reg   <= mem_rdata[DATA_W-1:0];
                vec_y_reg   <= mem_rdata[MEM_W-1:DATA_W];
                ncol_reg    <= '0;
                nrow_reg    <= '0;
                outside_reg <= 1'b0;
            end

            ST_NORM:
            begin
                if (step_reg == 3'd1)
                begin
                    prod_x_reg <= mac_prod;
                    negx_reg   <= diff_x[DATA_W+1];
                end
                if (step_reg == 3'd2)
                begin
                    prod_y_reg <= mac_prod;
                    negy_reg   <= diff_y[DATA_W+1];
                end
            end

            ST_EVAL:
            begin
                cx_reg <= hi_x[IDX_W-1:0];
                cy_reg <= hi_y[IDX_W-1:0];
                wx_reg <= prod_x_reg[2*FRAC_BITS-1:FRAC_BITS];
                wy_reg <= prod_y_reg[2*FRAC_BITS-1:FRAC_BITS];
                if (req_reg == REQ_NEAREST)
                begin
                    vec_x_reg   <= '0;
                    vec_y_reg   <= '0;
                    ncol_reg    <= near_col;
                    nrow_reg    <= near_row;
                    outside_reg <= 1'b0;
                end
                else if (sample_out)
                begin
                    vec_x_reg   <= '0;
                    vec_y_reg   <= '0;
                    ncol_reg    <= '0;
                    nrow_reg    <= '0;
                    outside_reg <= 1'b1;
                end
            end

            ST_CORNER:
            begin
                if (step_reg != 3'd0)
                begin
                    if (in_memory(cap_col, cap_row))
                    begin
                        cor_x_reg[cap_k] <= mem_rdata[DATA_W-1:0];
                        cor_y_reg[cap_k] <= mem_rdata[MEM_W-1:DATA_W];
                    end
                    else
                    begin
                        cor_x_reg[cap_k] <= '0;
                        cor_y_reg[cap_k] <= '0;
                    end
                end
            end

            ST_LERP:
            begin
                if (step_reg >= 3'd1 && step_reg <= 3'd4)
                begin
                    t_reg[cap_k] <= mac_lerp;
                end
                if (step_reg == 3'd5)
                begin
                    vec_x_reg <= mac_lerp;
                end
                if (step_reg == 3'd6)
                begin
                    vec_y_reg   <= mac_lerp;
                    ncol_reg    <= '0;
                    nrow_reg    <= '0;
                    outside_reg <= 1'b0;
                end
            end

            default:
            begin
            end
        endcase
    end

    assign done        = done_reg;
    assign vec_x       = vec_x_reg;
    assign vec_y       = vec_y_reg;
    assign nearest_col = ncol_reg;
    assign nearest_row = nrow_reg;
    assign outside     = outside_reg;

endmodule

/* rtl/core/vgbs_checker.sv */
module vgbs_checker
    import vgbs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [2:0]               req_type,
    input logic                     done,
    input logic signed [DATA_W-1:0] vec_x,
    input logic signed [DATA_W-1:0] vec_y,
    input logic [IDX_W-1:0]         nearest_col,
    input logic [IDX_W-1:0]         nearest_row,
    input logic                     outside
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type != REQ_READ) |=> !done)
        else $error("result one cycle after a request that cannot answer that fast");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && outside) |->
            (vec_x == '0 && vec_y == '0 && nearest_col == '0 && nearest_row == '0))
        else $error("outside result carries data");

    a_nearest_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (nearest_col != '0 || nearest_row != '0)) |->
            (vec_x == '0 && vec_y == '0 && !outside))
        else $error("nearest result mixed with vector data");

endmodule

bind vector_grid_bilinear_sampler vgbs_checker u_vgbs_checker (.*);

/* tb/grid_answer_checker.sv */
`timescale 1ns / 100ps

module grid_answer_checker
    import vgbs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [2:0]               req_type,
    input  logic [IDX_W-1:0]         node_col,
    input  logic [IDX_W-1:0]         node_row,
    input  logic signed [DATA_W-1:0] value_x,
    input  logic signed [DATA_W-1:0] value_y,
    input  logic signed [DATA_W-1:0] pos_x,
    input  logic signed [DATA_W-1:0] pos_y,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     done,
    input  logic signed [DATA_W-1:0] vec_x,
    input  logic signed [DATA_W-1:0] vec_y,
    input  logic [IDX_W-1:0]         nearest_col,
    input  logic [IDX_W-1:0]         nearest_row,
    input  logic                     outside,
    output int                       fail_count,
    output int                       answers_waiting,
    output int                       answers_seen
);

    localparam longint      ONE_FX    = longint'(1) << FRAC_BITS;
    localparam longint      HALF_FX   = ONE_FX / 2;
    localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

    typedef struct packed {
        logic [DATA_W-1:0] vx;
        logic [DATA_W-1:0] vy;
        logic [IDX_W-1:0]  col;
        logic [IDX_W-1:0]  row;
        logic              off;
    } grid_answer_t;

    grid_answer_t answers_due[$];
    grid_answer_t ans;
    grid_answer_t want;

    logic signed [DATA_W-1:0] node_x [NODE_COUNT];
    logic signed [DATA_W-1:0] node_y [NODE_COUNT];

    logic signed [DATA_W-1:0] org_x;
    logic signed [DATA_W-1:0] org_y;
    logic [DATA_W-1:0]        scale_x;
    logic [DATA_W-1:0]        scale_y;
    logic [IDX_W-1:0]         across_cells;
    logic [IDX_W-1:0]         down_cells;

    logic [63:0] nx;
    logic [63:0] ny;
    logic        negx;
    logic        negy;
    longint      wx;
    longint      wy;
    int          cx;
    int          cy;
    int          slot;

    function automatic logic on_grid(input logic [IDX_W-1:0] col,
                                     input logic [IDX_W-1:0] row);
        return col <= across_cells && row <= down_cells;
    endfunction

    function automatic longint stored(input logic pick_y, input int col, input int row);
        if (col >= MAX_NODES_PER_SIDE || row >= MAX_NODES_PER_SIDE)
            return 0;
        if (pick_y)
            return longint'(node_y[row * MAX_NODES_PER_SIDE + col]);
        return longint'(node_x[row * MAX_NODES_PER_SIDE + col]);
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint w);
        return (a * (ONE_FX - w) + b * w + HALF_FX) >>> FRAC_BITS;
    endfunction

    function automatic longint bilinear(input logic pick_y, input int col, input int row,
                                        input longint fx, input longint fy);
        return blend(blend(stored(pick_y, col, row), stored(pick_y, col, row + 1), fy),
                     blend(stored(pick_y, col + 1, row), stored(pick_y, col + 1, row + 1), fy),
                     fx);
    endfunction

    // floored grid coordinate; true when the exact product is below zero
    function automatic logic scale_to_grid(input logic signed [DATA_W-1:0] pos,
                                           input logic signed [DATA_W-1:0] org,
                                           input logic [DATA_W-1:0] scale,
                                           output logic [63:0] n);
        longint      diff;
        logic [63:0] mag;
        logic [63:0] prod;
        diff = longint'(pos) - longint'(org);
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        prod = mag * 64'(scale);
        n    = '0;
        if (diff < 0 && prod != 0)
            return 1'b1;
        n = prod >> FRAC_BITS;
        return 1'b0;
    endfunction

    function automatic logic [IDX_W-1:0] nearest_node(input logic signed [DATA_W-1:0] pos,
                                                      input logic signed [DATA_W-1:0] org,
                                                      input logic [DATA_W-1:0] scale,
                                                      input logic [IDX_W-1:0] cells);
        logic [63:0] n;
        logic [63:0] idx;
        if (scale_to_grid(pos, org, scale, n))
            return '0;
        if (n >= (64'(cells) << FRAC_BITS))
            return cells;
        idx = (n + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (idx > 64'(cells)) ? cells : IDX_W'(idx);
    endfunction

    task automatic flag(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] exp_val);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, exp_val);
        fail_count++;
    endtask

    task automatic check_field(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] exp_val);
        if (got !== exp_val)
            flag(what, got, exp_val);
    endtask

    initial
    begin
        fail_count      = 0;
        answers_seen    = 0;
        answers_waiting = 0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            node_x[i] = '0;
            node_y[i] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x        = '0;
            org_y        = '0;
            scale_x      = 32'h0001_0000;
            scale_y      = 32'h0001_0000;
            across_cells = 6'd63;
            down_cells   = 6'd63;
            answers_due.delete();
            answers_waiting <= 0;
        end
        else
        begin
            if (done)
            begin
                answers_seen <= answers_seen + 1;
                if (answers_due.size() == 0)
                    flag("result with no request waiting", '0, '0);
                else
                begin
                    want = answers_due.pop_front();
                    check_field("vec_x", vec_x, want.vx);
                    check_field("vec_y", vec_y, want.vy);
                    check_field("nearest_col", DATA_W'(nearest_col), DATA_W'(want.col));
                    check_field("nearest_row", DATA_W'(nearest_row), DATA_W'(want.row));
                    check_field("outside", DATA_W'(outside), DATA_W'(want.off));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X:     org_x        = cfg_data;
                    CFG_ORIGIN_Y:     org_y        = cfg_data;
                    CFG_CELLS_UNIT_X: scale_x      = cfg_data;
                    CFG_CELLS_UNIT_Y: scale_y      = cfg_data;
                    CFG_CELLS_ACROSS: across_cells = cfg_data[IDX_W-1:0];
                    CFG_CELLS_DOWN:   down_cells   = cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end

            if (start && !busy)
            begin
                ans = '0;
                case (req_type)
                    REQ_SET, REQ_ADD:
                    begin
                        if (on_grid(node_col, node_row))
                        begin
                            slot = int'(node_row) * MAX_NODES_PER_SIDE + int'(node_col);
                            if (req_type == REQ_SET)
                            begin
                                node_x[slot] = value_x;
                                node_y[slot] = value_y;
                            end
                            else
                            begin
                                node_x[slot] = node_x[slot] + value_x;
                                node_y[slot] = node_y[slot] + value_y;
                            end
                        end
                    end
                    REQ_READ:
                    begin
                        if (on_grid(node_col, node_row))
                        begin
                            ans.vx = DATA_W'(stored(1'b0, int'(node_col), int'(node_row)));
                            ans.vy = DATA_W'(stored(1'b1, int'(node_col), int'(node_row)));
                        end
                        else
                            ans.off = 1'b1;
                        answers_due.push_back(ans);
                    end
                    REQ_SAMPLE:
                    begin
                        negx = scale_to_grid(pos_x, org_x, scale_x, nx);
                        negy = scale_to_grid(pos_y, org_y, scale_y, ny);
                        if (negx || negy || nx >= (64'(across_cells) << FRAC_BITS) ||
                            ny >= (64'(down_cells) << FRAC_BITS))
                            ans.off = 1'b1;
                        else
                        begin
                            cx     = int'(nx >> FRAC_BITS);
                            cy     = int'(ny >> FRAC_BITS);
                            wx     = longint'(nx & FRAC_MASK);
                            wy     = longint'(ny & FRAC_MASK);
                            ans.vx = DATA_W'(bilinear(1'b0, cx, cy, wx, wy));
                            ans.vy = DATA_W'(bilinear(1'b1, cx, cy, wx, wy));
                        end
                        answers_due.push_back(ans);
                    end
                    REQ_NEAREST:
                    begin
                        ans.col = nearest_node(pos_x, org_x, scale_x, across_cells);
                        ans.row = nearest_node(pos_y, org_y, scale_y, down_cells);
                        answers_due.push_back(ans);
                    end
                    default: ;
                endcase
            end

            answers_waiting <= answers_due.size();
        end
    end

endmodule

/* tb/vector_grid_bilinear_sampler_tb.sv */
`timescale 1ns / 100ps

module vector_grid_bilinear_sampler_tb;
    import vgbs_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          PHASES        = 8;
    localparam int          PER_PHASE     = 166;
    localparam int          BAND          = 4;
    localparam int          FILL_COUNT    = NODE_COUNT - (MAX_NODES_PER_SIDE - BAND) *
                                                         (MAX_NODES_PER_SIDE - BAND);
    localparam logic [2:0]  REQ_SPARE_LO  = 3'd5;
    localparam logic [2:0]  REQ_SPARE_HI  = 3'd7;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic                     busy;
    logic [2:0]               req_type  = REQ_SET;
    logic [IDX_W-1:0]         node_col  = '0;
    logic [IDX_W-1:0]         node_row  = '0;
    logic signed [DATA_W-1:0] value_x   = '0;
    logic signed [DATA_W-1:0] value_y   = '0;
    logic signed [DATA_W-1:0] pos_x     = '0;
    logic signed [DATA_W-1:0] pos_y     = '0;
    logic                     cfg_we    = 1'b0;
    logic [2:0]               cfg_index = CFG_ORIGIN_X;
    logic [DATA_W-1:0]        cfg_data  = '0;
    logic                     done;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic [IDX_W-1:0]         nearest_col;
    logic [IDX_W-1:0]         nearest_row;
    logic                     outside;

    int fail_count;
    int answers_waiting;
    int answers_seen;

    int unsigned cycle_count    = 0;
    int          sent_count     = 0;
    int          settings_count = 0;
    logic        gaps_on        = 1'b1;

    logic [DATA_W-1:0] set_ox  = '0;
    logic [DATA_W-1:0] set_oy  = '0;
    logic [DATA_W-1:0] set_spx = 32'h0001_0000;
    logic [DATA_W-1:0] set_spy = 32'h0001_0000;
    logic [IDX_W-1:0]  set_ca  = 6'd63;
    logic [IDX_W-1:0]  set_cd  = 6'd63;

    vector_grid_bilinear_sampler dut (.*);

    grid_answer_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("vector_grid_bilinear_sampler regression: fail");
            $finish;
        end
    end

    task automatic rest(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send(input logic [2:0] kind, input logic [IDX_W-1:0] col,
                        input logic [IDX_W-1:0] row, input logic [DATA_W-1:0] vx,
                        input logic [DATA_W-1:0] vy, input logic [DATA_W-1:0] px,
                        input logic [DATA_W-1:0] py);
        if (gaps_on && $urandom_range(0, 99) < 12)
            rest($urandom_range(1, 19));
        start    <= 1'b1;
        req_type <= kind;
        node_col <= col;
        node_row <= row;
        value_x  <= vx;
        value_y  <= vy;
        pos_x    <= px;
        pos_y    <= py;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
    endtask

    // drop start, wait out every pending answer, then let the block go quiet
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (answers_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [DATA_W-1:0] ox, input logic [DATA_W-1:0] oy,
                                 input logic [DATA_W-1:0] spx, input logic [DATA_W-1:0] spy,
                                 input logic [IDX_W-1:0] ca, input logic [IDX_W-1:0] cd);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_CELLS_UNIT_X, spx);
        write_reg(CFG_CELLS_UNIT_Y, spy);
        write_reg(CFG_CELLS_ACROSS, DATA_W'(ca));
        write_reg(CFG_CELLS_DOWN, DATA_W'(cd));
        cfg_we  <= 1'b0;
        set_ox  = ox;
        set_oy  = oy;
        set_spx = spx;
        set_spy = spy;
        set_ca  = ca;
        set_cd  = cd;
        settings_count++;
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:          return 32'h8000_0000;
            1:          return 32'h7FFF_FFFF;
            2, 3, 4, 5: return DATA_W'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
            default:    return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_node(input logic [IDX_W-1:0] cells);
        if ($urandom_range(0, 4) == 0)
            return IDX_W'($urandom);
        return IDX_W'($urandom_range(0, cells));
    endfunction

    function automatic logic [DATA_W-1:0] pick_origin();
        if ($urandom_range(0, 3) != 0)
            return DATA_W'(int'($urandom_range(0, 200)) - 100) << FRAC_BITS;
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 32'h0001_0000;
            9:       return $urandom;
            default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
        endcase
    endfunction

    // aim mostly inside the domain, some just below it, some at its far boundary
    function automatic logic [DATA_W-1:0] aim_pos(input logic [DATA_W-1:0] org,
                                                  input logic [DATA_W-1:0] scale,
                                                  input logic [IDX_W-1:0] cells);
        logic [63:0] reach;
        logic [63:0] rim;
        int          roll;
        roll  = $urandom_range(0, 9);
        reach = (scale == 0) ? 64'hFFFF_FFFF : ((64'(cells) + 64'd1) << DATA_W) / 64'(scale);
        rim   = (scale == 0) ? 64'hFFFF_FFFF : (64'(cells) << DATA_W) / 64'(scale);
        if (reach > 64'hFFFF_FFFF)
            reach = 64'hFFFF_FFFF;
        case (roll)
            0:       return $urandom;
            1:       return org - DATA_W'($urandom_range(0, 255));
            2:       return org + DATA_W'(rim) + DATA_W'(int'($urandom_range(0, 4)) - 2);
            default: return org + DATA_W'({$urandom, $urandom} % (reach + 64'd1));
        endcase
    endfunction

    task automatic random_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            send(REQ_SET, pick_node(set_ca), pick_node(set_cd), pick_word(), pick_word(),
                 $urandom, $urandom);
        else if (roll < 24)
            send(REQ_ADD, pick_node(set_ca), pick_node(set_cd), pick_word(), pick_word(),
                 $urandom, $urandom);
        else if (roll < 40)
            send(REQ_READ, pick_node(set_ca), pick_node(set_cd), $urandom, $urandom,
                 $urandom, $urandom);
        else if (roll < 78)
            send(REQ_SAMPLE, IDX_W'($urandom), IDX_W'($urandom), $urandom, $urandom,
                 aim_pos(set_ox, set_spx, set_ca), aim_pos(set_oy, set_spy, set_cd));
        else if (roll < 97)
            send(REQ_NEAREST, IDX_W'($urandom), IDX_W'($urandom), $urandom, $urandom,
                 aim_pos(set_ox, set_spx, set_ca), aim_pos(set_oy, set_spy, set_cd));
        else
            send(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), IDX_W'($urandom),
                 IDX_W'($urandom), $urandom, $urandom, $urandom, $urandom);
    endtask

    // keep one cell count under BAND so every reachable node lies in the filled band
    task automatic random_settings(input int phase);
        logic [IDX_W-1:0] wide;
        logic [IDX_W-1:0] narrow;
        case (phase)
            0: load_settings('0, '0, 32'h0001_0000, 32'h0001_0000, 6'd63, IDX_W'(BAND - 1));
            1: load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             6'd1, 6'd1);
            2: load_settings(pick_origin(), pick_origin(), '0, 32'd1, 6'd63, 6'd1);
            default:
            begin
                wide   = IDX_W'($urandom_range(1, 63));
                narrow = IDX_W'($urandom_range(1, BAND - 1));
                if ($urandom_range(0, 1) == 0)
                    load_settings(pick_origin(), pick_origin(), pick_scale(), pick_scale(),
                                  wide, narrow);
                else
                    load_settings(pick_origin(), pick_origin(), pick_scale(), pick_scale(),
                                  narrow, wide);
            end
        endcase
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the first BAND rows and columns; reads and sample corners stay inside them
        for (int row = 0; row < MAX_NODES_PER_SIDE; row++)
            for (int col = 0; col < MAX_NODES_PER_SIDE; col++)
                if (row < BAND || col < BAND)
                    send(REQ_SET, IDX_W'(col), IDX_W'(row), pick_word(), pick_word(),
                         $urandom, $urandom);
        settle();

        load_settings('0, '0, 32'h0001_0000, 32'h0001_0000, 6'd63, IDX_W'(BAND - 1));
        send(REQ_SET, 6'd5, 6'd2, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
        send(REQ_ADD, 6'd5, 6'd2, 32'h0000_0001, 32'hFFFF_FFFF, '0, '0);
        send(REQ_READ, 6'd5, 6'd2, '0, '0, '0, '0);
        send(REQ_READ, 6'd63, 6'd3, '0, '0, '0, '0);
        send(REQ_READ, 6'd0, 6'd0, '0, '0, '0, '0);
        send(REQ_SAMPLE, '0, '0, '0, '0, '0, '0);
        send(REQ_SAMPLE, '0, '0, '0, '0, 32'h003E_FFFF, 32'h0002_FFFF);
        send(REQ_SAMPLE, '0, '0, '0, '0, 32'h003F_0000, 32'h0000_8000);
        send(REQ_SAMPLE, '0, '0, '0, '0, 32'hFFFF_FFFF, 32'h0001_0000);
        send(REQ_SAMPLE, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        send(REQ_NEAREST, '0, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        send(REQ_NEAREST, '0, '0, '0, '0, 32'h0000_8000, 32'h0000_7FFF);
        send(REQ_NEAREST, '0, '0, '0, '0, 32'h003E_8000, 32'h0002_7FFF);
        send(REQ_SPARE_LO, 6'd1, 6'd1, 32'h1, 32'h1, '0, '0);
        send(REQ_SPARE_HI, 6'd1, 6'd1, 32'h1, 32'h1, '0, '0);
        settle();

        // no cells across, zero and full-scale scale factors
        load_settings(32'h8000_0000, 32'h7FFF_FFFF, '0, 32'hFFFF_FFFF, 6'd0, 6'd1);
        send(REQ_SAMPLE, '0, '0, '0, '0, 32'h1234_5678, 32'h7FFF_FFFF);
        send(REQ_NEAREST, '0, '0, '0, '0, 32'h1234_5678, 32'h7FFF_FFFF);
        send(REQ_NEAREST, '0, '0, '0, '0, '0, 32'h8000_0000);
        send(REQ_SET, 6'd1, 6'd0, 32'h0BAD_0000, 32'h0BAD_0000, '0, '0);
        send(REQ_ADD, 6'd1, 6'd0, 32'h0001_0000, 32'h0001_0000, '0, '0);
        send(REQ_READ, 6'd1, 6'd0, '0, '0, '0, '0);
        send(REQ_READ, 6'd0, 6'd1, '0, '0, '0, '0);
        send(REQ_READ, 6'd0, 6'd2, '0, '0, '0, '0);
        settle();

        load_settings('0, '0, '0, 32'h0001_0000, 6'd2, 6'd2);
        send(REQ_SAMPLE, '0, '0, '0, '0, 32'h8000_0000, 32'h0001_8000);
        send(REQ_READ, 6'd1, 6'd0, '0, '0, '0, '0);
        settle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            random_settings(phase);
            gaps_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (PER_PHASE) random_request();
            settle();
        end

        $display("Covered %0d requests, %0d of them the grid fill, over %0d register settings.",
                 sent_count, FILL_COUNT, settings_count);
        $display("Checked %0d answers: node reads, samples inside and outside, nearest nodes.",
                 answers_seen);
        if (fail_count == 0 && answers_waiting == 0)
            $display("vector_grid_bilinear_sampler regression: pass");
        else
            $display("vector_grid_bilinear_sampler regression: fail");
        $finish;
    end

endmodule
